FILE: hw/rtl/wall_column_texel_stepper_assert.svh
// Assertion macros for the wall column texel stepper.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef WALL_COLUMN_TEXEL_STEPPER_ASSERT_SVH
`define WALL_COLUMN_TEXEL_STEPPER_ASSERT_SVH

// Same-cycle implication.
`define WCTS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define WCTS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/wcts_pkg.sv
// Shared constants, types and helper functions for the wall column texel stepper.
// No dependencies; compiled first.
package wcts_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int COORD_BITS   = 12;
  localparam int LOG_BITS     = 4;
  localparam int MAX_TEX_LOG2 = 8;
  localparam int TEX_BITS     = 8;
  localparam int LINE_BITS    = 16;
  localparam int POS_BITS     = 24;
  localparam int DIR_BITS     = 18;
  localparam int FIX_BITS     = 2 * FRAC_BITS;
  localparam int DVD_BITS     = FRAC_BITS + MAX_TEX_LOG2 + 1;
  localparam int CNT_BITS     = $clog2(DVD_BITS);
  localparam int MUL_A_BITS   = DVD_BITS + 1;
  localparam int OFFSET_BITS  = LINE_BITS + 2;
  localparam int IDX_BITS     = 2;

  typedef enum logic [IDX_BITS-1:0] {
    REG_SCREEN_HEIGHT   = 2'd0,
    REG_TEX_WIDTH_LOG2  = 2'd1,
    REG_TEX_HEIGHT_LOG2 = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT,
    ST_DIV,
    ST_POS
  } state_t;

  function automatic logic [LOG_BITS-1:0] sat_log2(input logic [LOG_BITS-1:0] v);
    return (v > LOG_BITS'(MAX_TEX_LOG2)) ? LOG_BITS'(MAX_TEX_LOG2) : v;
  endfunction

  // Low lg bits set, lg at most MAX_TEX_LOG2.
  function automatic logic [TEX_BITS-1:0] tex_mask(input logic [LOG_BITS-1:0] lg);
    return TEX_BITS'(((TEX_BITS+1)'(1) << lg) - (TEX_BITS+1)'(1));
  endfunction

endpackage

FILE: hw/rtl/wcts_channels.sv
// Valid/ready channel interfaces: column/pixel step requests in, pixel rows out.
// Depends on wcts_pkg for field widths.
interface wcts_step_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  cmd;
  logic [wcts_pkg::COORD_BITS-1:0]       column_x;
  logic [wcts_pkg::COORD_BITS-1:0]       first_row;
  logic [wcts_pkg::COORD_BITS-1:0]       stop_row;
  logic [wcts_pkg::LINE_BITS-1:0]        wall_rows;
  logic [1:0]                            side;
  logic [wcts_pkg::POS_BITS-1:0]         pos_x;
  logic [wcts_pkg::POS_BITS-1:0]         pos_y;
  logic [wcts_pkg::POS_BITS-1:0]         perp_dist;
  logic signed [wcts_pkg::DIR_BITS-1:0]  dir_x;
  logic signed [wcts_pkg::DIR_BITS-1:0]  dir_y;

  modport source (output valid, cmd, column_x, first_row, stop_row, wall_rows, side,
                  pos_x, pos_y, perp_dist, dir_x, dir_y, input ready);
  modport sink (input valid, cmd, column_x, first_row, stop_row, wall_rows, side,
                pos_x, pos_y, perp_dist, dir_x, dir_y, output ready);
endinterface

interface wcts_pixel_if;
  logic                              valid;
  logic                              ready;
  logic [wcts_pkg::COORD_BITS-1:0]   screen_x;
  logic [wcts_pkg::COORD_BITS-1:0]   screen_y;
  logic [1:0]                        tex_select;
  logic [wcts_pkg::TEX_BITS-1:0]     texel_x;
  logic [wcts_pkg::TEX_BITS-1:0]     texel_y;
  logic                              last;

  modport source (output valid, screen_x, screen_y, tex_select, texel_x, texel_y, last,
                  input ready);
  modport sink (input valid, screen_x, screen_y, tex_select, texel_x, texel_y, last,
                output ready);
endinterface

FILE: hw/rtl/wcts_divider.sv
// Restoring divider, one quotient bit per cycle, for the texture step.
// Depends on wcts_pkg.
module wcts_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [wcts_pkg::DVD_BITS-1:0]      dividend,
  input  logic [wcts_pkg::LINE_BITS-1:0]     divisor,
  output logic                               busy,
  output logic [wcts_pkg::DVD_BITS-1:0]      quotient
);

  logic [wcts_pkg::DVD_BITS-1:0]   dvd;
  logic [wcts_pkg::LINE_BITS-1:0]  rem;
  logic [wcts_pkg::LINE_BITS-1:0]  dsr;
  logic [wcts_pkg::CNT_BITS-1:0]   cnt;
  logic [wcts_pkg::LINE_BITS:0]    trial;
  logic [wcts_pkg::LINE_BITS+1:0]  diff;
  logic                            fits;

  assign trial = {rem, dvd[wcts_pkg::DVD_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr};
  assign fits  = !diff[wcts_pkg::LINE_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      rem      <= '0;
      dsr      <= divisor;
      quotient <= '0;
      cnt      <= wcts_pkg::CNT_BITS'(wcts_pkg::DVD_BITS - 1);
    end else if (busy) begin
      dvd      <= dvd << 1;
      rem      <= fits ? diff[wcts_pkg::LINE_BITS-1:0] : trial[wcts_pkg::LINE_BITS-1:0];
      quotient <= {quotient[wcts_pkg::DVD_BITS-2:0], fits};
      cnt      <= cnt - wcts_pkg::CNT_BITS'(1);
    end
  end

endmodule

FILE: hw/rtl/wcts_mul.sv
// Shared signed multiplier with registered product, low word kept.
// Depends on wcts_pkg.
module wcts_mul (
  input  logic                                  clk,
  input  logic signed [wcts_pkg::MUL_A_BITS-1:0] a,
  input  logic signed [wcts_pkg::DIR_BITS-1:0]   b,
  output logic [wcts_pkg::FIX_BITS-1:0]          product
);

  logic signed [wcts_pkg::MUL_A_BITS+wcts_pkg::DIR_BITS-1:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    product <= full[wcts_pkg::FIX_BITS-1:0];
  end

endmodule

FILE: hw/rtl/wall_column_texel_stepper.sv
// Wall column texel stepper top level: sequencer, state and output register.
// Depends on wcts_pkg, wcts_channels, wcts_divider, wcts_mul and the assert header.
//
// Usage:
//   step  : valid/ready request channel. cmd 0 starts a column (latches the
//           column, computes texture column, step and start position);
//           cmd 1 produces the next pixel row of the column.
//   pixel : valid/ready result channel, one transaction per live pixel step,
//           last set on the final row. A step past the draw end emits nothing.
//   cfg_* : write-only register port (screen height, texture size logs); the user
//           must write it only while the block is idle, which the block does not enforce.
//   A row is registered and shown in the cycle after its step is accepted, and
//   a new step is taken while that row waits, provided the receiver takes it
//   in the same cycle.
//   A column start runs one multiply for the wall hit while the bit-serial
//   divider computes the step, then one multiply for the start position. Both
//   multiplies share one multiplier. ready is low throughout.
//   Reset (synchronous, active high) clears the column state, restores the
//   register defaults (480, 6, 6) and empties the output register. A stalled
//   receiver holds the row and blocks further requests.
module wall_column_texel_stepper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [wcts_pkg::IDX_BITS-1:0]     cfg_index,
  input  logic [wcts_pkg::COORD_BITS-1:0]   cfg_data,
  wcts_step_if.sink                         step,
  wcts_pixel_if.source                      pixel
);

  `include "wall_column_texel_stepper_assert.svh"

  wcts_pkg::state_t state;
  wcts_pkg::state_t state_next;

  logic [wcts_pkg::COORD_BITS-1:0]  screen_height;
  logic [wcts_pkg::LOG_BITS-1:0]    tex_width_log2;
  logic [wcts_pkg::LOG_BITS-1:0]    tex_height_log2;

  logic [wcts_pkg::COORD_BITS-1:0]  current_row;
  logic [wcts_pkg::COORD_BITS-1:0]  end_row;
  logic [wcts_pkg::COORD_BITS-1:0]  column_latch;
  logic [1:0]                       side_latch;
  logic [wcts_pkg::TEX_BITS-1:0]    texture_column;
  logic [wcts_pkg::FIX_BITS-1:0]    tex_position;
  logic [wcts_pkg::FIX_BITS-1:0]    tex_step;

  logic [wcts_pkg::FRAC_BITS-1:0]   pos_frac;
  logic                             mirror;
  logic [wcts_pkg::LOG_BITS-1:0]    wlog;
  logic [wcts_pkg::OFFSET_BITS-1:0] offset;

  logic                             pix_valid;
  logic [wcts_pkg::COORD_BITS-1:0]  pix_screen_x;
  logic [wcts_pkg::COORD_BITS-1:0]  pix_screen_y;
  logic [1:0]                       pix_tex_select;
  logic [wcts_pkg::TEX_BITS-1:0]    pix_texel_x;
  logic [wcts_pkg::TEX_BITS-1:0]    pix_texel_y;
  logic                             pix_last;

  logic step_take, col_start, pix_take, row_live, pix_emit;
  logic ew, mirror_in, div_start, div_busy;
  logic [wcts_pkg::LINE_BITS-1:0]   lh_eff;
  logic [wcts_pkg::LOG_BITS-1:0]    hlog_now;
  logic [wcts_pkg::DVD_BITS-1:0]    dividend;
  logic [wcts_pkg::DVD_BITS-1:0]    div_quotient;
  logic [wcts_pkg::OFFSET_BITS-1:0] offset_in;
  logic [wcts_pkg::MUL_A_BITS-1:0]  mul_a;
  logic [wcts_pkg::DIR_BITS-1:0]    mul_b;
  logic [wcts_pkg::FIX_BITS-1:0]    mul_prod;
  logic [wcts_pkg::FIX_BITS-1:0]    hit;
  logic [wcts_pkg::TEX_BITS-1:0]    tx_raw;
  logic [wcts_pkg::TEX_BITS-1:0]    tx_final;
  logic [wcts_pkg::COORD_BITS-1:0]  row_inc;

  assign step.ready = (state == wcts_pkg::ST_IDLE) && (!pix_valid || pixel.ready);
  assign step_take  = step.valid && step.ready;
  assign col_start  = step_take && !step.cmd;
  assign pix_take   = step_take && step.cmd;
  assign row_live   = current_row < end_row;
  assign pix_emit   = pix_take && row_live;
  assign row_inc    = current_row + wcts_pkg::COORD_BITS'(1);

  // Column start operands
  assign ew        = step.side[1];
  assign lh_eff    = (step.wall_rows == '0) ? wcts_pkg::LINE_BITS'(1) : step.wall_rows;
  assign hlog_now  = wcts_pkg::sat_log2(tex_height_log2);
  assign dividend  = wcts_pkg::DVD_BITS'(1)
                     << (wcts_pkg::CNT_BITS'(hlog_now) + wcts_pkg::CNT_BITS'(wcts_pkg::FRAC_BITS));
  assign offset_in = wcts_pkg::OFFSET_BITS'(step.first_row)
                     - wcts_pkg::OFFSET_BITS'(screen_height >> 1)
                     + wcts_pkg::OFFSET_BITS'(lh_eff >> 1);
  assign mirror_in = ew ? (!step.dir_x[wcts_pkg::DIR_BITS-1] && step.dir_x != '0)
                        : step.dir_y[wcts_pkg::DIR_BITS-1];

  // Multiplier operand select: wall hit while idle, start position otherwise
  assign mul_a = (state == wcts_pkg::ST_IDLE) ? wcts_pkg::MUL_A_BITS'(step.perp_dist)
                                              : wcts_pkg::MUL_A_BITS'(div_quotient);
  assign mul_b = (state == wcts_pkg::ST_IDLE) ? (ew ? step.dir_y : step.dir_x)
                                              : wcts_pkg::DIR_BITS'(offset);

  // Fractional hit and texture column
  assign hit      = {pos_frac, {wcts_pkg::FRAC_BITS{1'b0}}} + mul_prod;
  assign tx_raw   = hit[wcts_pkg::FIX_BITS-1 -: wcts_pkg::TEX_BITS]
                    >> (wcts_pkg::LOG_BITS'(wcts_pkg::MAX_TEX_LOG2) - wlog);
  assign tx_final = mirror ? (tx_raw ^ wcts_pkg::tex_mask(wlog)) : tx_raw;

  wcts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (lh_eff),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  wcts_mul u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      wcts_pkg::ST_IDLE: begin
        if (col_start) begin
          state_next = wcts_pkg::ST_HIT;
          div_start  = 1'b1;
        end
      end
      wcts_pkg::ST_HIT: begin
        state_next = wcts_pkg::ST_DIV;
      end
      wcts_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_next = wcts_pkg::ST_POS;
        end
      end
      wcts_pkg::ST_POS: begin
        state_next = wcts_pkg::ST_IDLE;
      end
      default: begin
        state_next = wcts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height   <= wcts_pkg::COORD_BITS'(480);
      tex_width_log2  <= wcts_pkg::LOG_BITS'(6);
      tex_height_log2 <= wcts_pkg::LOG_BITS'(6);
      current_row     <= '0;
      end_row         <= '0;
      column_latch    <= '0;
      side_latch      <= '0;
      texture_column  <= '0;
      tex_position    <= '0;
      tex_step        <= '0;
      pix_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          wcts_pkg::REG_SCREEN_HEIGHT:   screen_height   <= cfg_data;
          wcts_pkg::REG_TEX_WIDTH_LOG2:  tex_width_log2  <= cfg_data[wcts_pkg::LOG_BITS-1:0];
          wcts_pkg::REG_TEX_HEIGHT_LOG2: tex_height_log2 <= cfg_data[wcts_pkg::LOG_BITS-1:0];
          default: ;
        endcase
      end
      if (pix_emit) begin
        pix_valid <= 1'b1;
      end else if (pixel.ready) begin
        pix_valid <= 1'b0;
      end
      if (col_start) begin
        current_row  <= step.first_row;
        end_row      <= step.stop_row;
        column_latch <= step.column_x;
        side_latch   <= step.side;
      end
      if (pix_emit) begin
        current_row  <= row_inc;
        tex_position <= tex_position + tex_step;
      end
      if (state == wcts_pkg::ST_HIT) begin
        texture_column <= tx_final;
      end
      if (state == wcts_pkg::ST_POS) begin
        tex_position <= mul_prod;
        tex_step     <= wcts_pkg::FIX_BITS'(div_quotient);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_start) begin
      pos_frac <= ew ? step.pos_y[wcts_pkg::FRAC_BITS-1:0] : step.pos_x[wcts_pkg::FRAC_BITS-1:0];
      mirror   <= mirror_in;
      wlog     <= wcts_pkg::sat_log2(tex_width_log2);
      offset   <= offset_in;
    end
    if (pix_emit) begin
      pix_screen_x   <= column_latch;
      pix_screen_y   <= current_row;
      pix_tex_select <= side_latch;
      pix_texel_x    <= texture_column;
      pix_texel_y    <= tex_position[wcts_pkg::FRAC_BITS +: wcts_pkg::TEX_BITS]
                        & wcts_pkg::tex_mask(hlog_now);
      pix_last       <= (row_inc == end_row);
    end
  end

  assign pixel.valid      = pix_valid;
  assign pixel.screen_x   = pix_screen_x;
  assign pixel.screen_y   = pix_screen_y;
  assign pixel.tex_select = pix_tex_select;
  assign pixel.texel_x    = pix_texel_x;
  assign pixel.texel_y    = pix_texel_y;
  assign pixel.last       = pix_last;

  `WCTS_ASSERT_NXT(a_start_runs_div, clk, rst, col_start, state == wcts_pkg::ST_HIT && div_busy)
  `WCTS_ASSERT_NXT(a_div_to_pos, clk, rst, state == wcts_pkg::ST_DIV && !div_busy, state == wcts_pkg::ST_POS)
  `WCTS_ASSERT_NXT(a_row_shown, clk, rst, pix_emit, pixel.valid && pixel.screen_y == $past(current_row))
  `WCTS_ASSERT_NXT(a_dead_step_holds, clk, rst, pix_take && !row_live, $stable(tex_position) && $stable(current_row))

endmodule
